// ===== rtl/core/gpio_expander_shadow_control_unit_assert.svh =====
// Assertion macros for the GPIO expander shadow control unit.
// Expects clk and rst_n in the scope of use.
`ifndef GPIO_EXPANDER_SHADOW_CONTROL_UNIT_ASSERT_SVH
`define GPIO_EXPANDER_SHADOW_CONTROL_UNIT_ASSERT_SVH

// cond holds at every edge out of reset
`define GXS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gpio expander shadow: invariant violated");

// same-cycle implication
`define GXS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpio expander shadow: implication violated");

// next-cycle implication
`define GXS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpio expander shadow: next-cycle check violated");

`endif

// ===== rtl/core/gxs_pkg.sv =====
// Shared types and constants for the GPIO expander shadow control unit.
// No dependencies.
`timescale 1ns / 1ps

package gxs_pkg;

    localparam int PIN_COUNT      = 16;
    localparam int CHECK_INTERVAL = 5;

    localparam logic [3:0] OP_TOGGLE_LAZY = 4'd0;
    localparam logic [3:0] OP_TOGGLE      = 4'd1;
    localparam logic [3:0] OP_SET_LAZY    = 4'd2;
    localparam logic [3:0] OP_SET         = 4'd3;
    localparam logic [3:0] OP_GET         = 4'd4;
    localparam logic [3:0] OP_INVERT      = 4'd5;
    localparam logic [3:0] OP_DIRECTION   = 4'd6;
    localparam logic [3:0] OP_FLUSH       = 4'd7;
    localparam logic [3:0] OP_VERIFY      = 4'd8;

    localparam logic [1:0] REG_IN  = 2'd0;
    localparam logic [1:0] REG_OUT = 2'd1;
    localparam logic [1:0] REG_POL = 2'd2;
    localparam logic [1:0] REG_DIR = 2'd3;

    localparam logic [2:0] CFG_IDX_SWAP = 3'd0;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [3:0]  pin;
        logic        new_state;
        logic [15:0] live_input;
        logic        read_failed;
    } item_t;

    typedef struct packed {
        logic        value;
        logic        read_error;
        logic        write_request;
        logic [1:0]  write_register;
        logic [15:0] write_data;
    } result_t;

    typedef struct packed {
        logic [15:0] output_shadow;
        logic [15:0] polarity_shadow;
        logic [15:0] direction_shadow;
        logic        dirty_flag;
        logic [2:0]  check_counter;
        logic [31:0] match_count;
        logic [31:0] mismatch_count;
    } shadow_t;

endpackage

// ===== rtl/core/gxs_op_unit.sv =====
// Single-pass operation logic: next shadow state and result word for one item.
// Depends on gxs_pkg.
`timescale 1ns / 1ps

module gxs_op_unit
    import gxs_pkg::*;
(
    input  item_t   item,
    input  shadow_t cur,
    input  logic    swap_input_bytes,
    output shadow_t nxt,
    output result_t res
);

    logic [15:0] mask;
    logic        pin_ok;
    logic        cur_bit;
    logic        want_bit;
    logic [15:0] out_upd;
    logic        dirty_upd;
    logic [3:0]  cnt_inc;
    logic [15:0] cmp_word;

    always_comb
    begin
        mask      = 16'd1 << item.pin;
        pin_ok    = {1'b0, item.pin} < 5'(PIN_COUNT);
        cur_bit   = |(cur.output_shadow & mask);
        want_bit  = (item.opcode == OP_TOGGLE_LAZY || item.opcode == OP_TOGGLE)
                    ? ~cur_bit : item.new_state;
        out_upd   = want_bit ? (cur.output_shadow | mask) : (cur.output_shadow & ~mask);
        dirty_upd = cur.dirty_flag | (want_bit != cur_bit);
        cnt_inc   = {1'b0, cur.check_counter} + 4'd1;
        cmp_word  = swap_input_bytes ? {item.live_input[7:0], item.live_input[15:8]}
                                     : item.live_input;

        nxt = cur;
        res = '0;

        case (item.opcode) inside
            OP_TOGGLE_LAZY, OP_SET_LAZY:
            begin
                if (pin_ok)
                begin
                    nxt.output_shadow = out_upd;
                    nxt.dirty_flag    = dirty_upd;
                    res.value         = dirty_upd;
                end
            end
            OP_TOGGLE, OP_SET:
            begin
                if (pin_ok)
                begin
                    nxt.output_shadow = out_upd;
                    nxt.dirty_flag    = 1'b0;
                    if (dirty_upd)
                    begin
                        res.value          = 1'b1;
                        res.write_request  = 1'b1;
                        res.write_register = REG_OUT;
                        res.write_data     = out_upd;
                    end
                end
            end
            OP_GET:
            begin
                if (pin_ok)
                begin
                    if (|(cur.direction_shadow & mask))
                    begin
                        res.read_error = item.read_failed;
                        res.value      = ~item.read_failed & |(item.live_input & mask);
                    end
                    else
                    begin
                        res.value = cur_bit;
                    end
                end
            end
            OP_INVERT:
            begin
                if (pin_ok)
                begin
                    nxt.polarity_shadow = cur.polarity_shadow ^ mask;
                    res.write_request   = 1'b1;
                    res.write_register  = REG_POL;
                    res.write_data      = cur.polarity_shadow ^ mask;
                end
            end
            OP_DIRECTION:
            begin
                if (pin_ok)
                begin
                    nxt.direction_shadow = item.new_state ? (cur.direction_shadow | mask)
                                                          : (cur.direction_shadow & ~mask);
                    res.write_request    = 1'b1;
                    res.write_register   = REG_DIR;
                    res.write_data       = nxt.direction_shadow;
                end
            end
            OP_FLUSH:
            begin
                nxt.dirty_flag = 1'b0;
                if (cur.dirty_flag)
                begin
                    res.value          = 1'b1;
                    res.write_request  = 1'b1;
                    res.write_register = REG_OUT;
                    res.write_data     = cur.output_shadow;
                end
            end
            OP_VERIFY:
            begin
                // every CHECK_INTERVAL-th call only wraps the counter
                if (cnt_inc >= 4'(CHECK_INTERVAL))
                begin
                    nxt.check_counter = '0;
                end
                else
                begin
                    nxt.check_counter = cnt_inc[2:0];
                    if (cmp_word == cur.output_shadow)
                    begin
                        nxt.match_count = cur.match_count + 32'd1;
                    end
                    else
                    begin
                        nxt.mismatch_count = cur.mismatch_count + 32'd1;
                        res.value          = 1'b1;
                        res.write_request  = 1'b1;
                        res.write_register = REG_OUT;
                        res.write_data     = cur.output_shadow;
                    end
                end
            end
            default:
            begin
                nxt = cur;
                res = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/gpio_expander_shadow_control_unit.sv =====
// Shadow-register controller for a 16-pin GPIO expander: one operation word in, one result out,
// accepted at up to one word per clock. A word is captured in the input register, and once the
// result register is free or being read, the operation logic updates the shadow state as the
// result moves into the result register and m_tvalid rises. While a result waits on m_tready the
// input register holds one more word and s_tready then stays low until the result is taken.
// Depends on gxs_pkg, gxs_op_unit and gpio_expander_shadow_control_unit_assert.svh.
`timescale 1ns / 1ps

`include "gpio_expander_shadow_control_unit_assert.svh"

module gpio_expander_shadow_control_unit
    import gxs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] pin, [4] new_state, [20:5] live_input, [21] read_failed, [23:22] zero
    input  logic [23:0] s_tdata,
    // [3:0] opcode
    input  logic [3:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] value, [1] read_error, [2] write_request, [18:3] write_data, [23:19] zero
    output logic [23:0] m_tdata,
    // [1:0] write_register
    output logic [1:0]  m_tuser,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t res_reg;
    shadow_t shadow_reg;
    shadow_t shadow_next;
    result_t res_next;
    logic    swap_reg;
    logic    advance;
    logic    s_accept;
    logic    cfg_wr;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_SWAP[0]);
    assign prdata = (paddr[2] == CFG_IDX_SWAP[0]) ? {31'd0, swap_reg} : 32'd0;

    gxs_op_unit u_op (
        .item             (item_reg),
        .cur              (shadow_reg),
        .swap_input_bytes (swap_reg),
        .nxt              (shadow_next),
        .res              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            swap_reg <= pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.opcode      <= s_tuser;
            item_reg.pin         <= s_tdata[3:0];
            item_reg.new_state   <= s_tdata[4];
            item_reg.live_input  <= s_tdata[20:5];
            item_reg.read_failed <= s_tdata[21];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                shadow_reg <= shadow_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg.write_data, res_reg.write_request,
                       res_reg.read_error, res_reg.value};
    assign m_tuser  = res_reg.write_register;

    `GXS_ASSERT_ALWAYS(a_check_counter_range,
        shadow_reg.check_counter < 3'(CHECK_INTERVAL))
    `GXS_ASSERT_IMPL(a_no_write_fields_idle,
        m_tvalid && !res_reg.write_request,
        res_reg.write_register == REG_IN && res_reg.write_data == 16'd0)
    `GXS_ASSERT_IMPL(a_read_error_clean,
        m_tvalid && res_reg.read_error,
        !res_reg.value && !res_reg.write_request)
    `GXS_ASSERT_NEXT(a_flush_clears_dirty,
        advance && (item_reg.opcode == OP_FLUSH || item_reg.opcode == OP_SET
                    || item_reg.opcode == OP_TOGGLE) && res_next.write_request,
        !shadow_reg.dirty_flag)

endmodule
